### design/pwmt_pkg.sv
// ----------------------------------------------------------------------------
// pwmt_pkg
// shared types and constants for the pwm timer with duty stream
// ----------------------------------------------------------------------------
`default_nettype none
package pwmt_pkg;
  localparam int unsigned NumCh = 6;
  localparam int unsigned FifoDepth = 16;
  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned LvlW = $clog2(FifoDepth + 1);

  typedef enum logic [3:0] {
    ACT_TICK     = 4'd0,
    ACT_SET_DUTY = 4'd1,
    ACT_RD_MATCH = 4'd2,
    ACT_SET_CNT  = 4'd3,
    ACT_RD_CNT   = 4'd4,
    ACT_ENABLE   = 4'd5,
    ACT_DISABLE  = 4'd6,
    ACT_ST_BEGIN = 4'd7,
    ACT_ST_PUSH  = 4'd8,
    ACT_CANCEL   = 4'd9
  } action_e;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_DONE = 2'd1;
  localparam logic [1:0] EV_CANCEL = 2'd2;

  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_PRESCALE = 2'd1;
  localparam logic [1:0] REG_CH_EN = 2'd2;

  // decoded item passed from front to back
  typedef struct packed {
    logic [3:0]  action;
    logic [2:0]  channel;
    logic [31:0] value;
    logic        ch_valid;
  } item_t;

  typedef struct packed {
    logic [NumCh-1:0] pwm_out;
    logic [31:0]      read_data;
    logic [1:0]       status;
    logic [1:0]       event_res;
    logic             period_end;
  } result_t;
endpackage
`default_nettype wire

### design/pwmt_front.sv
// ----------------------------------------------------------------------------
// pwmt_front
// input stage: takes items and classifies the channel, two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none
module pwmt_front import pwmt_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       stall_o,
  input  wire logic [3:0]  action_i,
  input  wire logic [2:0]  channel_i,
  input  wire logic [31:0] value_i,
  output logic       q_valid_o,
  input  wire logic  q_pop_i,
  output item_t      q_item_o
);
  item_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push;
  item_t       it;

  assign stall_o = (cnt_q == 2'd2);
  assign push = valid_i && !stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o = mem_q[rp_q];

  always_comb begin
    it.action = action_i;
    it.channel = channel_i;
    it.value = value_i;
    it.ch_valid = (channel_i >= 3'd1) && ({29'd0, channel_i} <= NumCh[31:0]);
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= it;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule
`default_nettype wire

### design/pwmt_back.sv
// ----------------------------------------------------------------------------
// pwmt_back
// execution stage: counter, match registers, duty stream and result register
// ----------------------------------------------------------------------------
`default_nettype none
module pwmt_back import pwmt_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic  q_valid_i,
  output logic       q_pop_o,
  input  wire item_t q_item_i,
  output logic       res_valid_o,
  input  wire logic  res_stall_i,
  output result_t    res_o
);
  logic [31:0]      period_q, prescale_q;
  logic [NumCh-1:0] ch_en_q;
  logic [31:0]      cnt_q, cnt_d, pre_q, pre_d;
  logic             run_q, run_d;
  logic [31:0]      shadow_q [NumCh];
  logic [31:0]      shadow_d [NumCh];
  logic [31:0]      active_q [NumCh];
  logic [31:0]      active_d [NumCh];
  logic [NumCh-1:0] pend_q, pend_d;
  logic             st_q, st_d;
  logic [2:0]       st_ch_q, st_ch_d;
  logic [31:0]      rem_q, rem_d;
  logic [31:0]      fifo_q [FifoDepth];
  logic [LvlW-1:0]  lvl_q, lvl_d;
  logic [PtrW-1:0]  rp_q, rp_d, wp_q, wp_d;
  logic             fifo_we;
  logic             res_v_q;
  result_t          res_q, r;
  logic             go;

  assign go = q_valid_i && (!res_v_q || !res_stall_i);
  assign q_pop_o = go;
  assign res_valid_o = res_v_q;
  assign res_o = res_q;

  always_comb begin
    cnt_d = cnt_q; pre_d = pre_q; run_d = run_q; pend_d = pend_q;
    st_d = st_q; st_ch_d = st_ch_q; rem_d = rem_q;
    lvl_d = lvl_q; rp_d = rp_q; wp_d = wp_q; fifo_we = 1'b0;
    shadow_d = shadow_q; active_d = active_q;
    r = '0;
    unique case (q_item_i.action)
      ACT_TICK: begin
        if (run_q) begin
          if (pre_q >= prescale_q) begin
            pre_d = '0;
            if (cnt_q >= period_q) begin
              cnt_d = '0;
              r.period_end = 1'b1;
              for (int c = 0; c < NumCh; c++)
                if (pend_q[c]) active_d[c] = shadow_q[c];
              pend_d = '0;
              if (st_q) begin
                if (rem_q != '0) begin
                  if (lvl_q != '0) begin
                    rp_d = rp_q + 1'b1;
                    lvl_d = lvl_q - 1'b1;
                    // stream channel was checked at begin
                    for (int c = 0; c < NumCh; c++)
                      if (st_ch_q == 3'(c + 1)) begin
                        shadow_d[c] = fifo_q[rp_q];
                        pend_d[c] = 1'b1;
                      end
                  end
                  rem_d = rem_q - 32'd1;
                end else begin
                  st_d = 1'b0;
                  r.event_res = EV_DONE;
                end
              end
            end else cnt_d = cnt_q + 32'd1;
          end else pre_d = pre_q + 32'd1;
        end
      end
      ACT_SET_DUTY: begin
        if (st_q) r.status = ST_BUSY;
        else if (!q_item_i.ch_valid) r.status = ST_INVALID;
        else begin
          for (int c = 0; c < NumCh; c++)
            if (q_item_i.channel == 3'(c + 1)) begin
              shadow_d[c] = q_item_i.value;
              pend_d[c] = 1'b1;
            end
        end
      end
      ACT_RD_MATCH: begin
        if (q_item_i.channel == 3'd0) r.read_data = period_q;
        else if (q_item_i.ch_valid) begin
          for (int c = 0; c < NumCh; c++)
            if (q_item_i.channel == 3'(c + 1)) r.read_data = shadow_q[c];
        end else r.status = ST_INVALID;
      end
      ACT_SET_CNT: cnt_d = q_item_i.value;
      ACT_RD_CNT: r.read_data = cnt_q;
      ACT_ENABLE: run_d = 1'b1;
      ACT_DISABLE: run_d = 1'b0;
      ACT_ST_BEGIN: begin
        if (st_q) r.status = ST_BUSY;
        else if (!q_item_i.ch_valid) r.status = ST_INVALID;
        else begin
          st_d = 1'b1; st_ch_d = q_item_i.channel; rem_d = q_item_i.value;
          lvl_d = '0; rp_d = '0; wp_d = '0;
        end
      end
      ACT_ST_PUSH: begin
        if (lvl_q == LvlW'(FifoDepth)) r.status = ST_FULL;
        else begin
          fifo_we = 1'b1;
          wp_d = wp_q + 1'b1;
          lvl_d = lvl_q + 1'b1;
        end
      end
      ACT_CANCEL: begin
        if (st_q) begin
          st_d = 1'b0; rem_d = '0;
          lvl_d = '0; rp_d = '0; wp_d = '0;
          r.event_res = EV_CANCEL;
        end
      end
      default: ;
    endcase
    for (int c = 0; c < NumCh; c++)
      r.pwm_out[c] = ch_en_q[c] && (cnt_d < active_d[c]);
  end

  always_ff @(posedge clk_i) begin
    if (go && fifo_we) fifo_q[wp_q] <= q_item_i.value;
    if (go) res_q <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0; prescale_q <= '0; ch_en_q <= '0;
      cnt_q <= '0; pre_q <= '0; run_q <= 1'b0; pend_q <= '0;
      st_q <= 1'b0; st_ch_q <= '0; rem_q <= '0;
      lvl_q <= '0; rp_q <= '0; wp_q <= '0; res_v_q <= 1'b0;
      for (int c = 0; c < NumCh; c++) begin
        shadow_q[c] <= '0; active_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PERIOD: period_q <= cfg_data_i;
          REG_PRESCALE: prescale_q <= cfg_data_i;
          REG_CH_EN: ch_en_q <= cfg_data_i[NumCh-1:0];
          default: ;
        endcase
      end
      if (go) begin
        cnt_q <= cnt_d; pre_q <= pre_d; run_q <= run_d; pend_q <= pend_d;
        st_q <= st_d; st_ch_q <= st_ch_d; rem_q <= rem_d;
        lvl_q <= lvl_d; rp_q <= rp_d; wp_q <= wp_d;
        shadow_q <= shadow_d; active_q <= active_d;
        res_v_q <= 1'b1;
      end else if (!res_stall_i) res_v_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### design/pwm_timer_with_duty_stream_top.sv
// ----------------------------------------------------------------------------
// pwm_timer_with_duty_stream_top
// six-channel pwm timer with shadow match registers and a duty stream
// ----------------------------------------------------------------------------
// path: an input transfer passes through the input queue, then the result register
// throughput: one item per cycle while out_stall_i does not hold the result register
// reset: asynchronous, clears counter, matches, stream state and both queues
`default_nettype none
module pwm_timer_with_duty_stream_top import pwmt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  action_i,
  input  wire logic [2:0]  channel_i,
  input  wire logic [31:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [5:0]       pwm_out_o,
  output logic [31:0]      read_data_o,
  output logic [1:0]       status_o,
  output logic [1:0]       event_res_o,
  output logic             period_end_o
);
  logic    q_valid, q_pop;
  item_t   q_item;
  result_t res;

  pwmt_front u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .stall_o(in_stall_o),
    .action_i, .channel_i, .value_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  pwmt_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .res_valid_o(out_valid_o), .res_stall_i(out_stall_i), .res_o(res)
  );

  assign pwm_out_o = res.pwm_out;
  assign read_data_o = res.read_data;
  assign status_o = res.status;
  assign event_res_o = res.event_res;
  assign period_end_o = res.period_end;

  a_pend_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && period_end_o |-> status_o == ST_OK && read_data_o == '0)
    else $error("period end on a non-tick result");
  a_ev_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> event_res_o != 2'd3)
    else $error("bad event code");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o)
    else $error("executed item gave no result");
endmodule
`default_nettype wire

### tb/pwm_timer_with_duty_stream_top_test.sv
// ----------------------------------------------------------------------------
// pwm_timer_with_duty_stream_top_test
// drives random and table-driven actions into the pwm timer, predicts every
// result with a behavioural model of the timer and compares field by field
// ----------------------------------------------------------------------------
module pwm_timer_with_duty_stream_top_test;
  import pwmt_pkg::*;

  localparam int CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_PERIOD;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  action_i = '0;
  logic [2:0]  channel_i = '0;
  logic [31:0] value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [5:0]  pwm_out_o;
  logic [31:0] read_data_o;
  logic [1:0]  status_o;
  logic [1:0]  event_res_o;
  logic        period_end_o;

  pwm_timer_with_duty_stream_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // timer model state
  logic [31:0] m_period, m_prescale;
  logic [5:0]  m_ch_en;
  logic [31:0] m_count, m_pre_cnt;
  logic        m_running;
  logic [31:0] m_shadow [NumCh];
  logic [31:0] m_active [NumCh];
  logic [5:0]  m_pending;
  logic        m_st_active;
  logic [2:0]  m_st_ch;
  logic [31:0] m_st_left;
  logic [31:0] m_duty_q [$];

  result_t result_q [$];
  int errors = 0;
  int cycles = 0;
  int next_gap = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic void model_reset();
    m_period = 0; m_prescale = 0; m_ch_en = 0;
    m_count = 0; m_pre_cnt = 0; m_running = 0;
    for (int c = 0; c < NumCh; c++) begin
      m_shadow[c] = 0;
      m_active[c] = 0;
    end
    m_pending = 0; m_st_active = 0; m_st_ch = 0; m_st_left = 0;
    m_duty_q.delete();
  endfunction

  function automatic bit ch_ok(logic [2:0] ch);
    return ch >= 1 && ch <= NumCh;
  endfunction

  function automatic result_t timer_step(logic [3:0] act, logic [2:0] ch, logic [31:0] val);
    result_t r;
    r = '0;
    case (act)
      ACT_TICK: begin
        if (m_running) begin
          if (m_pre_cnt >= m_prescale) begin
            m_pre_cnt = 0;
            if (m_count >= m_period) begin
              m_count = 0;
              r.period_end = 1'b1;
              for (int c = 0; c < NumCh; c++)
                if (m_pending[c]) m_active[c] = m_shadow[c];
              m_pending = 0;
              if (m_st_active) begin
                if (m_st_left != 0) begin
                  if (m_duty_q.size() != 0) begin
                    m_shadow[m_st_ch - 1] = m_duty_q.pop_front();
                    m_pending[m_st_ch - 1] = 1'b1;
                  end
                  m_st_left--;
                end else begin
                  m_st_active = 0;
                  r.event_res = EV_DONE;
                end
              end
            end else begin
              m_count++;
            end
          end else begin
            m_pre_cnt++;
          end
        end
      end
      ACT_SET_DUTY: begin
        if (m_st_active) r.status = ST_BUSY;
        else if (!ch_ok(ch)) r.status = ST_INVALID;
        else begin
          m_shadow[ch - 1] = val;
          m_pending[ch - 1] = 1'b1;
        end
      end
      ACT_RD_MATCH: begin
        if (ch == 0) r.read_data = m_period;
        else if (ch_ok(ch)) r.read_data = m_shadow[ch - 1];
        else r.status = ST_INVALID;
      end
      ACT_SET_CNT: m_count = val;
      ACT_RD_CNT: r.read_data = m_count;
      ACT_ENABLE: m_running = 1'b1;
      ACT_DISABLE: m_running = 1'b0;
      ACT_ST_BEGIN: begin
        if (m_st_active) r.status = ST_BUSY;
        else if (!ch_ok(ch)) r.status = ST_INVALID;
        else begin
          m_st_active = 1'b1;
          m_st_ch = ch;
          m_st_left = val;
          m_duty_q.delete();
        end
      end
      ACT_ST_PUSH: begin
        if (m_duty_q.size() >= FifoDepth) r.status = ST_FULL;
        else m_duty_q.push_back(val);
      end
      ACT_CANCEL: begin
        if (m_st_active) begin
          m_st_active = 0;
          m_st_left = 0;
          m_duty_q.delete();
          r.event_res = EV_CANCEL;
        end
      end
      default: ;
    endcase
    for (int c = 0; c < NumCh; c++)
      if (m_ch_en[c] && m_count < m_active[c]) r.pwm_out[c] = 1'b1;
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PERIOD: m_period = data;
      REG_PRESCALE: m_prescale = data;
      default: m_ch_en = data[5:0];
    endcase
    @(posedge clk_i);
  endtask

  // wait for every expected result, then let the pipeline settle
  task automatic drain();
    if (next_gap == 0) in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // drive one item; when a known result is given it must match the model
  task automatic send(input logic [3:0] act, input logic [2:0] ch, input logic [31:0] val,
                      input bit fixed, input result_t want);
    result_t r;
    repeat (next_gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    action_i <= act;
    channel_i <= ch;
    value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = timer_step(act, ch, val);
    if (fixed && r.read_data != want.read_data)
      report("table row read_data", r.read_data, want.read_data);
    if (fixed && {r.pwm_out, r.status, r.event_res, r.period_end} !=
        {want.pwm_out, want.status, want.event_res, want.period_end})
      report("table row flags",
             {21'd0, r.pwm_out, r.status, r.event_res, r.period_end},
             {21'd0, want.pwm_out, want.status, want.event_res, want.period_end});
    result_q.push_back(r);
    // keep valid up for a back-to-back transfer, drop it before an idle gap
    next_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (next_gap != 0) in_valid_i <= 1'b0;
  endtask

  // output side: stall for a drawn number of cycles after each transfer
  initial begin
    result_t want;
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) report("unexpected transfer", 0, 0);
        else begin
          want = result_q.pop_front();
          if (pwm_out_o != want.pwm_out) report("pwm_out", pwm_out_o, want.pwm_out);
          if (read_data_o != want.read_data) report("read_data", read_data_o, want.read_data);
          if (status_o != want.status) report("status", status_o, want.status);
          if (event_res_o != want.event_res) report("event_res", event_res_o, want.event_res);
          if (period_end_o != want.period_end)
            report("period_end", period_end_o, want.period_end);
        end
        hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        out_stall_i <= (hold != 0);
      end else if (hold > 0) begin
        hold--;
        if (hold == 0) out_stall_i <= 1'b0;
      end
    end
  end

  typedef struct {
    logic [3:0]  act;
    logic [2:0]  ch;
    logic [31:0] val;
    bit          fixed;
    result_t     want;
  } row_t;

  function automatic result_t res(logic [31:0] rd, logic [1:0] st, logic [1:0] ev);
    result_t r;
    r = '0;
    r.read_data = rd;
    r.status = st;
    r.event_res = ev;
    return r;
  endfunction

  function automatic result_t res_pwm(logic [5:0] pwm, logic [31:0] rd, logic [1:0] st,
                                      logic [1:0] ev);
    result_t r;
    r = res(rd, st, ev);
    r.pwm_out = pwm;
    return r;
  endfunction

  task automatic rand_item(input int mode);
    logic [3:0] a;
    logic [2:0] ch;
    logic [31:0] v;
    int p;
    p = $urandom_range(0, 99);
    ch = 3'($urandom_range(1, 6));
    v = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 12);
    if (p < 55) a = ACT_TICK;
    else if (p < 63) a = ACT_ST_PUSH;
    else if (p < 68) begin a = ACT_ST_BEGIN; v = $urandom_range(0, 6); end
    else if (p < 73) a = ACT_SET_DUTY;
    else if (p < 77) a = ACT_RD_MATCH;
    else if (p < 80) a = ACT_RD_CNT;
    else if (p < 82) begin a = ACT_SET_CNT; v = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 8); end
    else if (p < 85) a = ACT_ENABLE;
    else if (p < 86) a = ACT_DISABLE;
    else if (p < 88) a = ACT_CANCEL;
    else begin
      a = 4'($urandom_range(0, 15));
      ch = 3'($urandom_range(0, 7));
      v = $urandom;
    end
    if (mode == 1 && a == ACT_DISABLE) a = ACT_TICK;
    send(a, ch, v, 1'b0, '0);
  endtask

  initial begin
    row_t rows [$];
    model_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(REG_PERIOD, 32'd3);
    write_reg(REG_PRESCALE, 32'd0);
    write_reg(REG_CH_EN, 32'h3F);

    rows = '{
      '{ACT_RD_MATCH, 3'd0, 32'd0, 1, res(32'd3, ST_OK, EV_NONE)},
      '{ACT_RD_CNT, 3'd0, 32'd0, 1, res(32'd0, ST_OK, EV_NONE)},
      '{ACT_RD_MATCH, 3'd7, 32'd0, 1, res(32'd0, ST_INVALID, EV_NONE)},
      '{ACT_SET_DUTY, 3'd0, 32'd5, 1, res(32'd0, ST_INVALID, EV_NONE)},
      '{ACT_SET_DUTY, 3'd7, 32'd5, 1, res(32'd0, ST_INVALID, EV_NONE)},
      '{ACT_SET_DUTY, 3'd1, 32'hFFFFFFFF, 0, '0},
      '{ACT_SET_DUTY, 3'd6, 32'd2, 0, '0},
      '{ACT_RD_MATCH, 3'd1, 32'd0, 1, res(32'hFFFFFFFF, ST_OK, EV_NONE)},
      '{ACT_TICK, 3'd0, 32'd0, 1, res(32'd0, ST_OK, EV_NONE)},
      '{ACT_ENABLE, 3'd0, 32'd0, 0, '0},
      '{ACT_SET_CNT, 3'd0, 32'd3, 0, '0},
      '{ACT_TICK, 3'd0, 32'd0, 0, '0},
      '{ACT_ST_BEGIN, 3'd0, 32'd1, 1, res_pwm(6'h21, 32'd0, ST_INVALID, EV_NONE)},
      '{ACT_ST_BEGIN, 3'd2, 32'd1, 0, '0},
      '{ACT_ST_BEGIN, 3'd2, 32'd1, 1, res_pwm(6'h21, 32'd0, ST_BUSY, EV_NONE)},
      '{ACT_SET_DUTY, 3'd2, 32'd1, 0, '0},
      '{ACT_ST_PUSH, 3'd0, 32'd9, 0, '0},
      '{ACT_TICK, 3'd0, 32'd0, 0, '0},
      '{ACT_TICK, 3'd0, 32'd0, 0, '0},
      '{ACT_CANCEL, 3'd0, 32'd0, 0, '0},
      '{ACT_CANCEL, 3'd0, 32'd0, 0, '0},
      '{ACT_SET_CNT, 3'd0, 32'hFFFFFFFF, 0, '0},
      '{4'd15, 3'd5, 32'hFFFFFFFF, 0, '0},
      '{ACT_DISABLE, 3'd0, 32'd0, 0, '0}
    };
    foreach (rows[i]) send(rows[i].act, rows[i].ch, rows[i].val, rows[i].fixed, rows[i].want);
    // fill the fifo past full
    for (int i = 0; i < FifoDepth + 2; i++) send(ACT_ST_PUSH, 3'd1, $urandom, 1'b0, '0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_PERIOD, 32'd4); write_reg(REG_PRESCALE, 32'd0); end
        1: begin write_reg(REG_PERIOD, 32'd0); write_reg(REG_PRESCALE, 32'd0); end
        2: begin write_reg(REG_PERIOD, 32'd7); write_reg(REG_PRESCALE, 32'd2); end
        3: begin write_reg(REG_PERIOD, 32'hFFFFFFFF); write_reg(REG_PRESCALE, 32'd1); end
        4: begin write_reg(REG_PERIOD, 32'd2); write_reg(REG_PRESCALE, 32'hFFFFFFFF); end
        default: begin write_reg(REG_PERIOD, $urandom_range(1, 9)); write_reg(REG_PRESCALE, 0); end
      endcase
      write_reg(REG_CH_EN, (ph == 1) ? 32'h0 : $urandom_range(0, 63));
      send(ACT_ENABLE, 3'd0, 32'd0, 1'b0, '0);
      // count near the top rarely wraps, so bring it back into range sometimes
      for (int i = 0; i < 230; i++) begin
        if (ph == 3 && i % 40 == 0) send(ACT_SET_CNT, 3'd0, $urandom_range(0, 1) ?
                                         32'hFFFFFFFE : 32'd0, 1'b0, '0);
        rand_item(1);
      end
      if (ph == 2) drain();  // sender holds off until all results are in
      drain();
    end
    drain();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
